### rtl/adpcm_memory_port_defines.svh
// Assertion macros used by adpcm_memory_port.sv.
`ifndef ADPCM_MEMORY_PORT_DEFINES_SVH
`define ADPCM_MEMORY_PORT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AMP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AMP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/amp_pkg.sv
`timescale 1ns / 1ps
package amp_pkg;
  localparam int ADDR_BITS = 18;
  localparam logic [ADDR_BITS-1:0] ADDR_MASK = '1;
  localparam int QW = 23;
  localparam int DW = 17;
  localparam logic [QW-1:0] DIVIDEND = 23'd4718592;

  typedef enum logic [1:0] {FN_SEL, FN_WRITE, FN_STATUS, FN_READ} func_e;
  typedef enum logic [2:0] {
    MODE_HALT, MODE_RECORD, MODE_REPLAY, MODE_WRITE, MODE_READ
  } mode_e;
  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIV, ST_MRD} state_e;

  localparam logic [7:0] REG_CTRL    = 8'h00;
  localparam logic [7:0] REG_UNIT    = 8'h01;
  localparam logic [7:0] REG_START_L = 8'h02;
  localparam logic [7:0] REG_START_H = 8'h03;
  localparam logic [7:0] REG_STOP_L  = 8'h04;
  localparam logic [7:0] REG_STOP_H  = 8'h05;
  localparam logic [7:0] REG_PRE_L   = 8'h06;
  localparam logic [7:0] REG_PRE_H   = 8'h07;
  localparam logic [7:0] REG_MEM     = 8'h08;
  localparam logic [7:0] REG_DELTA_L = 8'h09;
  localparam logic [7:0] REG_DELTA_H = 8'h0a;
  localparam logic [7:0] REG_LIMIT_L = 8'h0c;
  localparam logic [7:0] REG_LIMIT_H = 8'h0d;
  localparam logic [7:0] REG_FLAG    = 8'h10;

  localparam int CTRL_START = 7;
  localparam int CTRL_REC   = 6;
  localparam int CTRL_MEM   = 5;
  localparam int CTRL_RESET = 0;
  localparam int FLAG_CLR   = 7;
  localparam int MASK_BRDY  = 3;
  localparam int MASK_EOS   = 2;
endpackage

### rtl/adpcm_memory_port.sv
// An accepted word is worked on in ST_EXEC; a memory data read goes on through ST_MRD,
// and a write to a delta register through ST_DIV, where a 23-step divider works out the rate.
// The next word is taken in the cycle after the result word has been taken.
// Reset is asynchronous and resets the control state; the operand, divider and output
// registers and the sample memory are not cleared.
`timescale 1ns / 1ps
module adpcm_memory_port (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        start_event_o,
  output logic [22:0] rate_base_o,
  output logic        eos_armed_o,
  output logic [18:0] eos_length_o
);
  import amp_pkg::*;
  `include "adpcm_memory_port_defines.svh"

  state_e state_q, state_d;
  logic [1:0] func_q, func_d;
  logic [7:0] wdata_q, wdata_d;
  logic [7:0] sel_q, sel_d;
  logic [7:0] shadow_q [16];
  logic [7:0] shadow_d [16];
  logic [7:0] shadow_n [16];
  logic [2:0] unit_q, unit_d;
  logic [ADDR_BITS-1:0] start_q, start_d, stop_q, stop_d, limit_q, limit_d;
  logic [ADDR_BITS-1:0] acc_q, acc_d, acc_inc;
  logic [11:0] recrate_q, recrate_d;
  logic [QW-1:0] reprate_q, reprate_d;
  mode_e mode_q, mode_d;
  logic [1:0] dummy_q, dummy_d;
  logic brdy_q, brdy_d, eos_q, eos_d, busy_q, busy_d;
  logic pbrdy_q, pbrdy_d, peos_q, peos_d;
  logic [4:0] mask_q, mask_d;
  logic [DW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [4:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic [7:0] rd_q, rd_d;
  logic se_q, se_d, ea_q, ea_d;
  logic [22:0] rb_q, rb_d;
  logic [18:0] el_q, el_d;
  logic mem_we;
  logic [7:0] mem_q [2**ADDR_BITS];
  logic [7:0] mem_rdata_q;

  logic [15:0] p_start, p_stop, p_limit, p_delta;
  logic [10:0] p_pre;
  logic [31:0] start_w, stop_w, limit_w;
  logic [ADDR_BITS:0] len, len_p1;
  logic [DW:0] trial, diff;
  logic ge, finish, memon, rec, brdy_n, eos_n;

  assign in_stall_o    = (state_q != ST_IDLE) || out_valid_q;
  assign out_valid_o   = out_valid_q;
  assign read_data_o   = rd_q;
  assign start_event_o = se_q;
  assign rate_base_o   = rb_q;
  assign eos_armed_o   = ea_q;
  assign eos_length_o  = el_q;

  assign acc_inc = acc_q + 1'b1;

  always_comb begin
    shadow_n = shadow_q;
    if (sel_q[7:4] == 4'd0) begin
      shadow_n[sel_q[3:0]] = wdata_q;
    end
  end

  assign p_start = {shadow_n[REG_START_H[3:0]], shadow_n[REG_START_L[3:0]]};
  assign p_stop  = {shadow_n[REG_STOP_H[3:0]], shadow_n[REG_STOP_L[3:0]]};
  assign p_limit = {shadow_n[REG_LIMIT_H[3:0]], shadow_n[REG_LIMIT_L[3:0]]};
  assign p_delta = {shadow_n[REG_DELTA_H[3:0]], shadow_n[REG_DELTA_L[3:0]]};
  assign p_pre   = {shadow_n[REG_PRE_H[3:0]][2:0], shadow_n[REG_PRE_L[3:0]]};
  assign start_w = {16'd0, p_start} << unit_q;
  assign stop_w  = (({16'd0, p_stop} + 32'd1) << unit_q) - 32'd1;
  assign limit_w = (({16'd0, p_limit} + 32'd1) << unit_q) - 32'd1;

  always_comb begin
    if (stop_q == limit_q) begin
      len = (start_q < stop_q) ? {1'b0, stop_q - start_q} : {1'b0, ADDR_MASK - start_q};
    end else if (start_q < stop_q && start_q < limit_q) begin
      len = (stop_q < limit_q) ? {1'b0, stop_q - start_q} : '0;
    end else if (stop_q < start_q && stop_q < limit_q) begin
      len = (start_q < limit_q) ? {1'b0, limit_q - start_q} + {1'b0, stop_q}
                                : {1'b0, ADDR_MASK - start_q};
    end else begin
      len = (start_q < stop_q) ? {1'b0, stop_q - start_q} : {1'b0, ADDR_MASK - start_q};
    end
  end
  assign len_p1 = len + 1'b1;

  assign trial = {rem_q, quo_q[QW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  assign memon  = wdata_q[CTRL_MEM];
  assign rec    = wdata_q[CTRL_REC];
  assign brdy_n = (pbrdy_q && !mask_q[MASK_BRDY]) ? 1'b1 : brdy_q;
  assign eos_n  = (peos_q && !mask_q[MASK_EOS]) ? 1'b1 : eos_q;

  always_comb begin
    state_d = state_q;  func_d = func_q;  wdata_d = wdata_q;  sel_d = sel_q;
    shadow_d = shadow_q;  unit_d = unit_q;  start_d = start_q;  stop_d = stop_q;
    limit_d = limit_q;  acc_d = acc_q;  recrate_d = recrate_q;  reprate_d = reprate_q;
    mode_d = mode_q;  dummy_d = dummy_q;  brdy_d = brdy_q;  eos_d = eos_q;
    busy_d = busy_q;  pbrdy_d = pbrdy_q;  peos_d = peos_q;  mask_d = mask_q;
    rem_d = rem_q;  dvs_d = dvs_q;  quo_d = quo_q;  cnt_d = cnt_q;
    rd_d = rd_q;  se_d = se_q;  rb_d = rb_q;  ea_d = ea_q;  el_d = el_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we = 1'b0;
    finish = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          func_d  = func_i;
          wdata_d = data_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rd_d = 8'hff;  se_d = 1'b0;  rb_d = '0;  ea_d = 1'b0;  el_d = '0;
        finish = 1'b1;
        case (func_e'(func_q))
          FN_SEL: sel_d = wdata_q;
          FN_WRITE: begin
            shadow_d = shadow_n;
            case (sel_q)
              REG_CTRL: begin
                if (busy_q) begin
                  if (!memon) busy_d = 1'b0;
                end else if (memon) begin
                  if (wdata_q[CTRL_START]) begin
                    mode_d = rec ? MODE_RECORD : MODE_REPLAY;
                    se_d   = 1'b1;
                    rb_d   = rec ? {11'd0, recrate_q} : reprate_q;
                    if (len != '0) begin
                      ea_d = 1'b1;
                      el_d = 19'(len_p1);
                    end
                    busy_d = 1'b1;
                  end else begin
                    if (rec) begin
                      mode_d  = MODE_WRITE;
                      pbrdy_d = 1'b1;
                    end else begin
                      mode_d  = MODE_READ;
                      dummy_d = 2'd2;
                    end
                    acc_d = start_q;
                  end
                end
                if (wdata_q[CTRL_RESET]) busy_d = 1'b0;
                if (!memon) mode_d = MODE_HALT;
              end
              REG_UNIT: unit_d = wdata_q[1] ? 3'd5 : 3'd2;
              REG_START_L, REG_START_H: start_d = start_w[ADDR_BITS-1:0];
              REG_STOP_L, REG_STOP_H: stop_d = stop_w[ADDR_BITS-1:0];
              REG_LIMIT_L, REG_LIMIT_H: limit_d = limit_w[ADDR_BITS-1:0];
              REG_PRE_L, REG_PRE_H: recrate_d = (p_pre == '0) ? 12'h800 : {1'b0, p_pre};
              REG_DELTA_L, REG_DELTA_H: begin
                dvs_d   = (p_delta == '0) ? 17'h10000 : {1'b0, p_delta};
                rem_d   = '0;
                quo_d   = DIVIDEND;
                cnt_d   = '0;
                state_d = ST_DIV;
                finish  = 1'b0;
              end
              REG_MEM: begin
                if (mode_q == MODE_WRITE) begin
                  if (acc_q == stop_q || acc_q == ADDR_MASK) peos_d = 1'b1;
                  mem_we  = 1'b1;
                  acc_d   = acc_inc;
                  pbrdy_d = 1'b1;
                end
              end
              REG_FLAG: begin
                if (wdata_q[FLAG_CLR]) begin
                  brdy_d = 1'b0;
                  eos_d  = 1'b0;
                end else begin
                  mask_d = wdata_q[4:0];
                  if (wdata_q[MASK_EOS]) eos_d = 1'b0;
                  if (wdata_q[MASK_BRDY]) brdy_d = 1'b0;
                end
              end
              default: ;
            endcase
          end
          FN_STATUS: begin
            brdy_d  = brdy_n;
            eos_d   = eos_n;
            pbrdy_d = 1'b0;
            peos_d  = 1'b0;
            rd_d    = {2'b00, busy_q, 1'b0, brdy_n, eos_n, 2'b00};
          end
          FN_READ: begin
            if (sel_q == REG_MEM && mode_q == MODE_READ) begin
              if (dummy_q != 2'd0) begin
                dummy_d = dummy_q - 1'b1;
                if (acc_q != stop_q) brdy_d = !mask_q[MASK_BRDY];
              end else if (acc_q != stop_q) begin
                state_d = ST_MRD;
                finish  = 1'b0;
              end
            end
          end
          default: ;
        endcase
        if (finish) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_DIV: begin
        rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_d = {quo_q[QW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'(QW - 1)) begin
          reprate_d   = {quo_q[QW-2:0], ge};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_MRD: begin
        rd_d  = mem_rdata_q;
        acc_d = acc_inc;
        if (acc_inc != stop_q) brdy_d = !mask_q[MASK_BRDY];
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q <= 8'hff;
      for (int i = 0; i < 16; i++) shadow_q[i] <= '0;
      unit_q <= 3'd5;
      start_q <= '0;  stop_q <= '0;  limit_q <= '0;  acc_q <= '0;
      recrate_q <= 12'd1;
      reprate_q <= 23'd1;
      mode_q <= MODE_HALT;
      dummy_q <= 2'd2;
      brdy_q <= 1'b0;  eos_q <= 1'b0;  busy_q <= 1'b0;
      pbrdy_q <= 1'b0;  peos_q <= 1'b0;
      mask_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q <= sel_d;
      shadow_q <= shadow_d;
      unit_q <= unit_d;
      start_q <= start_d;  stop_q <= stop_d;  limit_q <= limit_d;  acc_q <= acc_d;
      recrate_q <= recrate_d;
      reprate_q <= reprate_d;
      mode_q <= mode_d;
      dummy_q <= dummy_d;
      brdy_q <= brdy_d;  eos_q <= eos_d;  busy_q <= busy_d;
      pbrdy_q <= pbrdy_d;  peos_q <= peos_d;
      mask_q <= mask_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    wdata_q <= wdata_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    rd_q <= rd_d;
    se_q <= se_d;
    rb_q <= rb_d;
    ea_q <= ea_d;
    el_q <= el_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[acc_q] <= wdata_q;
    end
    mem_rdata_q <= mem_q[acc_q];
  end

  `AMP_ASSERT_IMP(a_div_no_result, state_q == ST_DIV, !out_valid_q)
  `AMP_ASSERT_IMP(a_result_when_idle, out_valid_q, state_q == ST_IDLE)
  `AMP_ASSERT_IMP(a_start_sets_busy, out_valid_q && se_q, busy_q)
  `AMP_ASSERT_NXT(a_mrd_delivers, state_q == ST_MRD, out_valid_q)
endmodule
